// ===== rtl/ptwbq_pkg.sv =====
// ----------------------------------------------------------------------------
// ptwbq_pkg
// Shared types and constants for the per-type windowed byte quota policer.
// ----------------------------------------------------------------------------
`default_nettype none

package ptwbq_pkg;

	// Number of message types tracked by the policer.
	localparam int TYPE_COUNT = 1024;
	localparam int IDX_W      = $clog2(TYPE_COUNT);

	// Field widths.
	localparam int TYPE_W   = 32;
	localparam int SECOND_W = 32;
	localparam int LENGTH_W = 16;
	localparam int BUDGET_W = 16;
	localparam int OVHD_W   = 8;
	localparam int BYTES_W  = 17;
	localparam int COUNT_W  = 32;

	// Register reset values.
	localparam logic [BUDGET_W-1:0] BUDGET_RESET   = 16'd2048;
	localparam logic [OVHD_W-1:0]   OVERHEAD_RESET = 8'd12;

	// Register indexes, taken from the word address of the configuration port.
	localparam logic REG_BYTE_BUDGET = 1'b0;
	localparam logic REG_OVERHEAD    = 1'b1;

	// Per-event verdict codes.
	typedef enum logic [1:0] {
		VERDICT_FIRST    = 2'd0,
		VERDICT_WITHIN   = 2'd1,
		VERDICT_OVER     = 2'd2,
		VERDICT_BAD_TYPE = 2'd3
	} verdict_t;

	// One table entry: usage of the type in the tagged second and its admit count.
	typedef struct packed {
		logic                valid;
		logic [SECOND_W-1:0] tag;
		logic [BYTES_W-1:0]  bytes;
		logic [COUNT_W-1:0]  count;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// ===== rtl/ptwbq_ram.sv =====
// ----------------------------------------------------------------------------
// ptwbq_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ptwbq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port; read data holds while rd_en is low.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/per_type_windowed_byte_quota_top.sv =====
// Flow: an accepted event is registered in stage 1 with its table read, then judged into the output register.
// A new event is accepted only after the previous one has left stage 1, which reads and writes back the
// type's entry in the single table RAM; a stalled output register holds it there.
// Reset: registers return to their defaults at once; a clearing pass then writes all
// 1024 table entries, one per cycle, and events are accepted only after it ends.
// ----------------------------------------------------------------------------
// per_type_windowed_byte_quota_top
// Admission policer that enforces a per-second byte budget for each message type.
// ----------------------------------------------------------------------------
`default_nettype none

module per_type_windowed_byte_quota_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// Configuration port
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [2:0]                       paddr,
	input  wire logic [31:0]                      pwdata,
	output      logic [31:0]                      prdata,
	output      logic                             pready,
	// Event channel
	input  wire logic                             in_valid,
	output      logic                             in_ready,
	input  wire logic [ptwbq_pkg::TYPE_W-1:0]     event_type,
	input  wire logic [ptwbq_pkg::SECOND_W-1:0]   event_second,
	input  wire logic [ptwbq_pkg::LENGTH_W-1:0]   payload_length,
	// Result channel
	output      logic                             out_valid,
	input  wire logic                             out_ready,
	output      logic                             admitted,
	output      logic [1:0]                       verdict,
	output      logic [ptwbq_pkg::TYPE_W-1:0]     echoed_type,
	output      logic [ptwbq_pkg::COUNT_W-1:0]    admitted_total,
	output      logic [ptwbq_pkg::SECOND_W-1:0]   window_second
);

	import ptwbq_pkg::*;

	// Configuration registers.
	logic [BUDGET_W-1:0] budget_q;
	logic [OVHD_W-1:0]   overhead_q;

	// Clearing pass.
	logic             clr_done_q;
	logic [IDX_W-1:0] clr_idx_q;

	// Current window.
	logic [SECOND_W-1:0] window_q;

	// Stage 1: event waiting for its table entry.
	logic                s1_valid_q;
	logic [TYPE_W-1:0]   type_s1;
	logic [SECOND_W-1:0] second_s1;
	logic [LENGTH_W-1:0] len_s1;
	logic                inrange_s1;

	// Output register.
	logic                out_valid_q;
	logic                out_admit_q;
	verdict_t            out_verdict_q;
	logic [TYPE_W-1:0]   out_type_q;
	logic [COUNT_W-1:0]  out_total_q;
	logic [SECOND_W-1:0] out_window_q;

	// Table RAM ports.
	logic             ram_wr_en;
	logic [IDX_W-1:0] ram_wr_addr;
	entry_t           ram_wr_data;
	entry_t           ram_rd_data;

	// Datapath of the judgment.
	logic                in_fire;
	logic                s1_fire;
	logic                in_range;
	logic [SECOND_W-1:0] win;
	logic [BYTES_W-1:0]  cost;
	logic [BYTES_W:0]    sum;
	logic                live;
	logic                admit;
	verdict_t            vd;
	entry_t              upd;

	// Configuration port: writes complete in the access phase, reads are combinational.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q   <= BUDGET_RESET;
			overhead_q <= OVERHEAD_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_BYTE_BUDGET: budget_q   <= pwdata[BUDGET_W-1:0];
				REG_OVERHEAD:    overhead_q <= pwdata[OVHD_W-1:0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_BYTE_BUDGET: prdata = {{(32-BUDGET_W){1'b0}}, budget_q};
			REG_OVERHEAD:    prdata = {{(32-OVHD_W){1'b0}}, overhead_q};
			default:         prdata = '0;
		endcase
	end

	// Clearing pass over the table after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_done_q <= 1'b0;
			clr_idx_q  <= '0;
		end else if (!clr_done_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == IDX_W'(TYPE_COUNT - 1)) begin
				clr_done_q <= 1'b1;
			end
		end
	end

	// Handshakes: one event in flight between its table read and its write-back.
	assign in_ready = clr_done_q && !s1_valid_q;
	assign in_fire  = in_valid && in_ready;
	assign s1_fire  = s1_valid_q && (!out_valid_q || out_ready);
	assign in_range = event_type < TYPE_W'(TYPE_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_fire) begin
			s1_valid_q <= 1'b1;
		end else if (s1_fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			type_s1    <= event_type;
			second_s1  <= event_second;
			len_s1     <= payload_length;
			inrange_s1 <= in_range;
		end
	end

	// Judgment against the entry read when the event was accepted; the RAM holds it while the event waits.
	always_comb begin
		win   = (second_s1 > window_q) ? second_s1 : window_q;
		cost  = BYTES_W'(len_s1) + BYTES_W'(overhead_q);
		sum   = (BYTES_W+1)'(ram_rd_data.bytes) + (BYTES_W+1)'(cost);
		live  = ram_rd_data.valid && (ram_rd_data.tag == win);
		upd   = ram_rd_data;
		admit = 1'b0;
		priority if (!inrange_s1) begin
			vd = VERDICT_BAD_TYPE;
		end else if (!live) begin
			vd        = VERDICT_FIRST;
			admit     = 1'b1;
			upd.valid = 1'b1;
			upd.tag   = win;
			upd.bytes = cost;
		end else if (sum < (BYTES_W+1)'(budget_q)) begin
			vd        = VERDICT_WITHIN;
			admit     = 1'b1;
			upd.bytes = sum[BYTES_W-1:0];
		end else begin
			vd = VERDICT_OVER;
		end
		if (admit && (ram_rd_data.count != {COUNT_W{1'b1}})) begin
			upd.count = ram_rd_data.count + 1'b1;
		end
	end

	// Table RAM: zeros during the clearing pass, then the updated entry.
	always_comb begin
		if (!clr_done_q) begin
			ram_wr_en   = 1'b1;
			ram_wr_addr = clr_idx_q;
			ram_wr_data = '0;
		end else begin
			ram_wr_en   = s1_fire && inrange_s1;
			ram_wr_addr = type_s1[IDX_W-1:0];
			ram_wr_data = upd;
		end
	end

	ptwbq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TYPE_COUNT)
	) u_table (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (in_fire),
		.rd_addr(event_type[IDX_W-1:0]),
		.rd_data(ram_rd_data)
	);

	// Window advances only for in-range events.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (s1_fire && inrange_s1) begin
			window_q <= win;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			out_admit_q   <= admit;
			out_verdict_q <= vd;
			out_type_q    <= type_s1;
			out_total_q   <= inrange_s1 ? upd.count : '0;
			out_window_q  <= inrange_s1 ? win : window_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign admitted       = out_admit_q;
	assign verdict        = out_verdict_q;
	assign echoed_type    = out_type_q;
	assign admitted_total = out_total_q;
	assign window_second  = out_window_q;

endmodule

`default_nettype wire

// ===== bench/per_type_windowed_byte_quota_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_type_windowed_byte_quota_top_tb
// Self-checking bench for the per-type windowed byte quota policer. Events are
// driven through the valid/ready channel with random bursts and gaps, and
// results are drained by a receiver that stalls on its own pattern. A
// scoreboard keeps its own copy of the window, usage table and admit counters,
// predicts every verdict and compares each result transaction field by field.
// The budget and overhead registers are reprogrammed between phases over the
// configuration port and read back.
// ----------------------------------------------------------------------------
module per_type_windowed_byte_quota_top_tb;
	import ptwbq_pkg::*;

	localparam int RESET_CYCLES  = 12;
	localparam int LIMIT_CYCLES  = 400000;
	localparam int HOLD_CYCLES   = 120;
	localparam int PHASE_COUNT   = 6;
	localparam int PHASE_EVENTS  = 214;
	localparam int SETTLE_CYCLES = 4;
	localparam int MAX_PRINTED   = 40;

	// One predicted result transaction.
	typedef struct {
		logic                admit;
		verdict_t            verdict;
		logic [TYPE_W-1:0]   etype;
		logic [COUNT_W-1:0]  total;
		logic [SECOND_W-1:0] window;
	} quota_result_t;

	// Quota predictor plus the queue of verdicts still owed by the block.
	class quota_scoreboard;
		logic [BUDGET_W-1:0] budget;
		logic [OVHD_W-1:0]   overhead;
		logic [SECOND_W-1:0] window_now;
		bit                  live[TYPE_COUNT];
		logic [SECOND_W-1:0] tag[TYPE_COUNT];
		logic [BYTES_W-1:0]  used[TYPE_COUNT];
		logic [COUNT_W-1:0]  admits[TYPE_COUNT];
		quota_result_t       due[$];
		int                  errors;

		function new();
			budget     = BUDGET_RESET;
			overhead   = OVERHEAD_RESET;
			window_now = '0;
			errors     = 0;
			foreach (live[i]) begin
				live[i]   = 1'b0;
				tag[i]    = '0;
				used[i]   = '0;
				admits[i] = '0;
			end
		endfunction

		function int pending();
			return due.size();
		endfunction

		function void set_register(input logic idx, input logic [31:0] value);
			if (idx == REG_BYTE_BUDGET) begin
				budget = value[BUDGET_W-1:0];
			end else begin
				overhead = value[OVHD_W-1:0];
			end
		endfunction

		task report(input string msg);
			if (errors < MAX_PRINTED) begin
				$display("[%0t] mismatch: %s", $time, msg);
			end
			errors++;
		endtask

		// Judge one accepted event and queue the verdict it must produce.
		function void note_event(input logic [TYPE_W-1:0] etype,
		                         input logic [SECOND_W-1:0] sec,
		                         input logic [LENGTH_W-1:0] len);
			quota_result_t      r;
			int unsigned        idx;
			logic [BYTES_W-1:0] cost;
			logic [BYTES_W:0]   sum;
			r.admit = 1'b0;
			r.etype = etype;
			r.total = '0;
			if (etype >= TYPE_COUNT) begin
				// Unknown types leave the window and the table alone.
				r.verdict = VERDICT_BAD_TYPE;
			end else begin
				idx = etype;
				if (sec > window_now) begin
					window_now = sec;
				end
				cost = len + overhead;
				if (!live[idx] || tag[idx] != window_now) begin
					// First message of this type in the current second.
					live[idx] = 1'b1;
					tag[idx]  = window_now;
					used[idx] = cost;
					r.verdict = VERDICT_FIRST;
					r.admit   = 1'b1;
				end else begin
					sum = used[idx] + cost;
					if (sum < budget) begin
						used[idx] = sum[BYTES_W-1:0];
						r.verdict = VERDICT_WITHIN;
						r.admit   = 1'b1;
					end else begin
						r.verdict = VERDICT_OVER;
					end
				end
				if (r.admit && admits[idx] != '1) begin
					admits[idx]++;
				end
				r.total = admits[idx];
			end
			r.window = window_now;
			due.insert(due.size(), r);
		endfunction

		// Compare one result transaction with the oldest prediction.
		task check_result(input logic adm, input logic [1:0] vd,
		                  input logic [TYPE_W-1:0] etype, input logic [COUNT_W-1:0] total,
		                  input logic [SECOND_W-1:0] window);
			quota_result_t r;
			if (due.size() == 0) begin
				report($sformatf("result with nothing expected, type=%0d", etype));
			end else begin
				r = due.pop_front();
				if (adm !== r.admit || vd !== r.verdict || etype !== r.etype ||
				    total !== r.total || window !== r.window) begin
					report($sformatf({"got adm=%0b verdict=%0d type=%0d total=%0d win=%0d, ",
					                  "want adm=%0b verdict=%0d type=%0d total=%0d win=%0d"},
					                 adm, vd, etype, total, window, r.admit, r.verdict,
					                 r.etype, r.total, r.window));
				end
			end
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [2:0]          paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;
	logic                in_valid;
	logic                in_ready;
	logic [TYPE_W-1:0]   event_type;
	logic [SECOND_W-1:0] event_second;
	logic [LENGTH_W-1:0] payload_length;
	logic                out_valid;
	logic                out_ready;
	logic                admitted;
	logic [1:0]          verdict;
	logic [TYPE_W-1:0]   echoed_type;
	logic [COUNT_W-1:0]  admitted_total;
	logic [SECOND_W-1:0] window_second;

	quota_scoreboard     sb;
	bit                  hold_req = 1'b0;
	int unsigned         cycle_count = 0;
	logic [SECOND_W-1:0] next_second = '0;

	per_type_windowed_byte_quota_top u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.event_type     (event_type),
		.event_second   (event_second),
		.payload_length (payload_length),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.admitted       (admitted),
		.verdict        (verdict),
		.echoed_type    (echoed_type),
		.admitted_total (admitted_total),
		.window_second  (window_second)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("per_type_windowed_byte_quota_top_tb: FAIL");
			$finish;
		end
	end

	// Every result transaction is checked against the scoreboard.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_result(admitted, verdict, echoed_type, admitted_total, window_second);
		end
	end

	// Receiver: runs of random stall density, plus one long hold-off on request.
	initial begin : receive_side
		int run_left;
		int stall_pct;
		int hold_left;
		run_left  = 0;
		stall_pct = 0;
		hold_left = 0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (run_left == 0) begin
				run_left = $urandom_range(5, 60);
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 20;
					2: stall_pct = 50;
					default: stall_pct = 85;
				endcase
			end
			run_left--;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(1, 100) > stall_pct);
			end
		end
	end

	// Offer one event and hold it until the block takes it.
	task automatic offer_event(input logic [TYPE_W-1:0] etype, input logic [SECOND_W-1:0] sec,
	                           input logic [LENGTH_W-1:0] len);
		in_valid       <= 1'b1;
		event_type     <= etype;
		event_second   <= sec;
		payload_length <= len;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_event(etype, sec, len);
	endtask

	task automatic idle_sender(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Stop sending and wait until every owed result has come back.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly a few hot types in slowly advancing seconds, so budgets fill up.
	task automatic offer_random_event();
		int unsigned         pick;
		logic [TYPE_W-1:0]   etype;
		logic [SECOND_W-1:0] sec;
		logic [LENGTH_W-1:0] len;
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			next_second = next_second + $urandom_range(1, 3);
		end else if (pick == 3) begin
			next_second = next_second + $urandom_range(4, 100000);
		end
		sec = (pick >= 90) ? $urandom_range(0, next_second) : next_second;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			etype = $urandom_range(0, 7);
		end else if (pick < 76) begin
			etype = TYPE_COUNT - 1;
		end else if (pick < 88) begin
			etype = $urandom_range(0, TYPE_COUNT - 1);
		end else if (pick < 94) begin
			etype = $urandom_range(TYPE_COUNT, 2 * TYPE_COUNT - 1);
		end else begin
			etype = $urandom;
		end
		// Dropped types never move the window, so their second can be anything.
		if (etype >= TYPE_COUNT) begin
			sec = $urandom;
		end
		case ($urandom_range(0, 9))
			0: len = '0;
			1: len = '1;
			2, 3: len = LENGTH_W'($urandom);
			4: len = LENGTH_W'($urandom_range(0, sb.budget));
			default: len = LENGTH_W'($urandom_range(0, sb.budget / 8));
		endcase
		offer_event(etype, sec, len);
	endtask

	// Configuration port: setup phase, access phase, then back to idle.
	task automatic write_register(input logic idx, input logic [31:0] value);
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		pwrite  <= 1'b1;
		psel    <= 1'b1;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.set_register(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic read_register(input logic idx, output logic [31:0] value);
		paddr   <= {idx, 2'b00};
		pwrite  <= 1'b0;
		psel    <= 1'b1;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		value = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_quota_setting(input logic [31:0] budget_word,
	                                   input logic [31:0] overhead_word);
		logic [31:0] readback;
		write_register(REG_BYTE_BUDGET, budget_word);
		write_register(REG_OVERHEAD, overhead_word);
		read_register(REG_BYTE_BUDGET, readback);
		if (readback !== 32'(sb.budget)) begin
			sb.report($sformatf("budget readback %0d, want %0d", readback, sb.budget));
		end
		read_register(REG_OVERHEAD, readback);
		if (readback !== 32'(sb.overhead)) begin
			sb.report($sformatf("overhead readback %0d, want %0d", readback, sb.overhead));
		end
	endtask

	initial begin : stimulus
		int burst_left;
		int gap;
		sb             = new();
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		in_valid       = 1'b0;
		event_type     = '0;
		event_second   = '0;
		payload_length = '0;
		burst_left     = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed checks under the reset budget of 2048 and overhead of 12.
		offer_event(32'd0, 32'd0, 16'd0);          // first of second
		offer_event(32'd0, 32'd0, 16'd2024);       // lands exactly on the budget: refused
		offer_event(32'd0, 32'd0, 16'd2023);       // one byte below the budget: admitted
		offer_event(32'd0, 32'd0, 16'd0);          // full
		offer_event(TYPE_COUNT - 1, 32'd0, 16'hFFFF); // first may overshoot the budget
		offer_event(TYPE_COUNT - 1, 32'd0, 16'd0); // usage already above budget
		offer_event(TYPE_COUNT, 32'd5, 16'd100);   // just out of range, window stays put
		offer_event(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		offer_event(32'd0, 32'd1, 16'd10);         // next second forgets usage
		offer_event(32'd0, 32'd0, 16'd10);         // earlier second judged in the window
		offer_event(TYPE_COUNT - 1, 32'd1, 16'd0);
		offer_event(32'd512, 32'd3, 16'hAAAA);
		offer_event(32'd512, 32'd2, 16'd0);
		offer_event(32'd1, 32'd3, 16'h5555);
		offer_event(32'd1, 32'd3, 16'd5);
		offer_event(32'd2, 32'd3, 16'd5);
		offer_event(32'd2, 32'd3, 16'd5);
		wait_for_results();
		next_second = 32'd3;

		// Random phases, each under its own register setting.
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase)
				0: apply_quota_setting(32'd0, 32'd0);
				1: apply_quota_setting(32'h0000_FFFF, 32'h0000_00FF);
				2: apply_quota_setting(32'd1, 32'd0);
				3: apply_quota_setting($urandom_range(200, 5000), $urandom_range(0, 255));
				4: apply_quota_setting($urandom, $urandom);
				default: apply_quota_setting(32'd700, 32'd255);
			endcase
			// The receiver holds off for a long stretch while events keep coming.
			if (phase == 2) begin
				hold_req = 1'b1;
			end
			for (int n = 0; n < PHASE_EVENTS; n++) begin
				if (phase == 3 && n == PHASE_EVENTS / 2) begin
					wait_for_results();
				end
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					if (gap != 0) begin
						idle_sender(gap);
					end
				end
				burst_left--;
				offer_random_event();
			end
			wait_for_results();
		end

		// Last second representable: the window pins at the top.
		offer_event(32'd2, 32'hFFFF_FFFF, 16'd0);
		offer_event(32'd2, 32'hFFFF_FFFF, 16'd1);
		offer_event(32'd2, 32'd0, 16'd0);
		offer_event(TYPE_COUNT - 1, 32'hFFFF_FFFF, 16'hFFFF);
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (sb.pending() != 0) begin
			sb.report($sformatf("%0d results never arrived", sb.pending()));
		end
		if (sb.errors == 0) begin
			$display("per_type_windowed_byte_quota_top_tb: PASS");
		end else begin
			$display("per_type_windowed_byte_quota_top_tb: FAIL");
		end
		$finish;
	end

endmodule
